[rtl/clr_pkg.sv]
// Shared constants, types and codes for the clipped line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package clr_pkg;

	localparam int CW     = 16;                    // coordinate width
	localparam int DW     = CW + 1;                // delta width
	localparam int EW     = CW + 2;                // error term width
	localparam int DIMW   = 16;                    // clip width/height
	localparam int SW     = (CW > DIMW ? CW : DIMW) + 2; // clip compare width
	localparam int CFG_W  = (CW > DIMW ? CW : DIMW);
	localparam int IDX_W  = 2;
	localparam int COLW   = 32;
	localparam int IN_W   = 4 * CW + COLW;
	localparam int OUT_W  = 2 * CW + COLW;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [IDX_W-1:0] REG_CLIP_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_CLIP_HEIGHT = 2'd3;

	localparam logic [DIMW-1:0] CLIP_WIDTH_RST  = 16'd1024;
	localparam logic [DIMW-1:0] CLIP_HEIGHT_RST = 16'd768;

	typedef struct packed {
		logic signed [CW-1:0] left;
		logic signed [CW-1:0] top;
		logic [DIMW-1:0]      width;
		logic [DIMW-1:0]      height;
	} clip_t;

	typedef struct packed {
		logic                 valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 vis;
		logic [COLW-1:0]      color;
		logic                 last;
	} pix_t;

endpackage
`default_nettype wire

[rtl/clr_cfg.sv]
// Clip rectangle configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module clr_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [clr_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [clr_pkg::CFG_W-1:0]  cfg_data,
	output clr_pkg::clip_t                  clip
);
	import clr_pkg::*;

	clip_t clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= '0;
			clip_q.top    <= '0;
			clip_q.width  <= CLIP_WIDTH_RST;
			clip_q.height <= CLIP_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:   clip_q.left   <= cfg_data[CW-1:0];
				REG_CLIP_TOP:    clip_q.top    <= cfg_data[CW-1:0];
				REG_CLIP_WIDTH:  clip_q.width  <= cfg_data[DIMW-1:0];
				REG_CLIP_HEIGHT: clip_q.height <= cfg_data[DIMW-1:0];
				default: ;
			endcase
		end
	end

	assign clip = clip_q;

endmodule
`default_nettype wire

[rtl/clr_engine.sv]
// Bresenham line state, per-pixel step logic and clip test.
`timescale 1ns / 1ps
`default_nettype none
module clr_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire logic                        cmd,
	input  wire logic signed [clr_pkg::CW-1:0] x0,
	input  wire logic signed [clr_pkg::CW-1:0] y0,
	input  wire logic signed [clr_pkg::CW-1:0] x1,
	input  wire logic signed [clr_pkg::CW-1:0] y1,
	input  wire logic [clr_pkg::COLW-1:0]    color,
	input  clr_pkg::clip_t                   clip,
	output clr_pkg::pix_t                    res
);
	import clr_pkg::*;

	logic signed [CW-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [DW-1:0]        abs_dx_q;
	logic signed [DW-1:0] neg_abs_dy_q;
	logic                 dir_x_neg_q, dir_y_neg_q;
	logic signed [EW-1:0] err_q;
	logic [COLW-1:0]      color_q;
	logic                 active_q;

	// start setup
	logic signed [DW-1:0] dx, dy, abs_dx_n, neg_abs_dy_n;
	logic signed [EW-1:0] err_init;

	always_comb begin
		dx           = DW'(x1) - DW'(x0);
		dy           = DW'(y1) - DW'(y0);
		abs_dx_n     = (dx < 0) ? -dx : dx;
		neg_abs_dy_n = (dy < 0) ? dy : -dy;
		err_init     = signed'({1'b0, abs_dx_n}) + EW'(neg_abs_dy_n);
	end

	// step
	logic signed [EW:0]   e2, abs_e, neg_e;
	logic                 step_x, step_y, at_end;
	logic signed [EW-1:0] err_n;
	logic signed [CW-1:0] cur_x_n, cur_y_n;

	always_comb begin
		e2      = {err_q, 1'b0};
		abs_e   = signed'({2'b00, abs_dx_q});
		neg_e   = (EW+1)'(neg_abs_dy_q);
		step_x  = (e2 >= neg_e);
		step_y  = (e2 <= abs_e);
		at_end  = (cur_x_q == stop_x_q) && (cur_y_q == stop_y_q);
		err_n   = err_q + (step_x ? EW'(neg_abs_dy_q) : EW'(0))
		                + (step_y ? EW'(signed'({1'b0, abs_dx_q})) : EW'(0));
		cur_x_n = step_x ? (dir_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1)) : cur_x_q;
		cur_y_n = step_y ? (dir_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1)) : cur_y_q;
	end

	// clip test: left <= x < left + width, same for y
	logic signed [SW-1:0] cx, cy, lft, tp, rgt, bot;
	logic                 vis;

	always_comb begin
		cx  = SW'(cur_x_q);
		cy  = SW'(cur_y_q);
		lft = SW'(clip.left);
		tp  = SW'(clip.top);
		rgt = lft + signed'(SW'(clip.width));
		bot = tp + signed'(SW'(clip.height));
		vis = (cx >= lft) && (cx < rgt) && (cy >= tp) && (cy < bot);
	end

	logic do_step;
	assign do_step = fire && (cmd == CMD_STEP) && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			stop_x_q     <= '0;
			stop_y_q     <= '0;
			abs_dx_q     <= '0;
			neg_abs_dy_q <= '0;
			dir_x_neg_q  <= 1'b0;
			dir_y_neg_q  <= 1'b0;
			err_q        <= '0;
			color_q      <= '0;
			active_q     <= 1'b0;
		end else if (fire && (cmd == CMD_START)) begin
			cur_x_q      <= x0;
			cur_y_q      <= y0;
			stop_x_q     <= x1;
			stop_y_q     <= y1;
			abs_dx_q     <= abs_dx_n;
			neg_abs_dy_q <= neg_abs_dy_n;
			dir_x_neg_q  <= !(x0 < x1);
			dir_y_neg_q  <= !(y0 < y1);
			err_q        <= err_init;
			color_q      <= color;
			active_q     <= 1'b1;
		end else if (do_step) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				cur_x_q <= cur_x_n;
				cur_y_q <= cur_y_n;
				err_q   <= err_n;
			end
		end
	end

	always_comb begin
		res.valid = do_step;
		res.x     = cur_x_q;
		res.y     = cur_y_q;
		res.vis   = vis;
		res.color = color_q;
		res.last  = at_end;
	end

	a_res_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> active_q)
		else $error("pixel emitted with no active line");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && at_end) |=> !active_q)
		else $error("line still active after its endpoint");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd == CMD_START) |=> active_q)
		else $error("start transfer did not arm the line");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(cur_x_q) && $stable(cur_y_q) && $stable(err_q)))
		else $error("line position moved without a transfer");

endmodule
`default_nettype wire

[rtl/clr_out_reg.sv]
// Result register between the step logic and the master stream.
`timescale 1ns / 1ps
`default_nettype none
module clr_out_reg (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  clr_pkg::pix_t res,
	input  wire logic   m_ready,
	output wire logic   s_ready,
	output wire logic   m_valid,
	output clr_pkg::pix_t pix
);
	import clr_pkg::*;

	logic valid_q;
	pix_t pix_q;

	assign s_ready = !valid_q || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			pix_q <= res;
		end
	end

	assign m_valid = valid_q;
	assign pix     = pix_q;

endmodule
`default_nettype wire

[rtl/clipped_line_rasterizer_top.sv]
// Top level of the clipped Bresenham line rasterizer.
// An accepted step's pixel is registered and appears on the master side in the next cycle.
// Throughput: one transfer per cycle (start or step) while the master side is ready.
// Each step is a single pass through the add/compare logic on the line registers.
// Reset (arst_n low) clears the line state, drops any pending pixel and restores the clip
// rectangle to left 0, top 0, width 1024, height 768.
`timescale 1ns / 1ps
`default_nettype none
module clipped_line_rasterizer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [clr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [clr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        s_tvalid,
	output wire logic                        s_tready,
	// line_x0, line_y0, line_x1, line_y1, line_color
	input  wire logic [clr_pkg::IN_W-1:0]    s_tdata,
	// cmd
	input  wire logic                        s_tuser,
	output wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	// pix_x, pix_y, pixel_value
	output wire logic [clr_pkg::OUT_W-1:0]   m_tdata,
	// visible
	output wire logic                        m_tuser,
	output wire logic                        m_tlast
);
	import clr_pkg::*;

	clip_t clip;
	pix_t  res;
	pix_t  pix;
	logic  fire;

	assign fire = s_tvalid && s_tready;

	clr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.clip      (clip)
	);

	clr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (s_tuser),
		.x0     (s_tdata[CW-1:0]),
		.y0     (s_tdata[2*CW-1:CW]),
		.x1     (s_tdata[3*CW-1:2*CW]),
		.y1     (s_tdata[4*CW-1:3*CW]),
		.color  (s_tdata[4*CW+COLW-1:4*CW]),
		.clip   (clip),
		.res    (res)
	);

	clr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.m_ready (m_tready),
		.s_ready (s_tready),
		.m_valid (m_tvalid),
		.pix     (pix)
	);

	assign m_tdata = {pix.color, pix.y, pix.x};
	assign m_tuser = pix.vis;
	assign m_tlast = pix.last;

endmodule
`default_nettype wire

[verif/clipped_line_rasterizer_top_tb.sv]
// Self-checking testbench for the clipped line rasterizer: predicts every pixel and checks the stream.
`timescale 1ns / 1ps
module clipped_line_rasterizer_top_tb;

	localparam int IN_W  = clr_pkg::IN_W;
	localparam int OUT_W = clr_pkg::OUT_W;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               vis;
		logic [31:0]        color;
		logic               last;
	} pixel_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [clr_pkg::IDX_W-1:0] cfg_index = '0;
	logic [clr_pkg::CFG_W-1:0] cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	wire                       s_tready;
	logic [IN_W-1:0]           s_tdata   = '0;   // line_x0, line_y0, line_x1, line_y1, line_color
	logic                      s_tuser   = 1'b0; // cmd
	wire                       m_tvalid;
	logic                      m_tready  = 1'b0;
	wire  [OUT_W-1:0]          m_tdata;          // pix_x, pix_y, pixel_value
	wire                       m_tuser;          // visible
	wire                       m_tlast;

	// clip rectangle as the block should hold it
	longint clp_left = 0, clp_top = 0, clp_w = 1024, clp_h = 768;
	// line walker state
	longint ln_x = 0, ln_y = 0, ln_end_x = 0, ln_end_y = 0;
	longint ln_adx = 0, ln_nady = 0, ln_err = 0;
	bit ln_xneg = 0, ln_yneg = 0, ln_active = 0;
	logic [31:0] ln_color = '0;

	pixel_t pixel_q[$];
	int err_count  = 0;
	int items_sent = 0;
	logic calm     = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left  = 0;

	clipped_line_rasterizer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [IN_W-1:0] line_word(logic [15:0] x0, logic [15:0] y0,
			logic [15:0] x1, logic [15:0] y1, logic [31:0] color);
		return {color, y1, x1, y0, x0};
	endfunction

	function automatic void predict_raster(logic cmd, logic [IN_W-1:0] d);
		pixel_t p;
		longint e2;
		if (cmd == clr_pkg::CMD_START) begin
			ln_x     = sx16(d[15:0]);
			ln_y     = sx16(d[31:16]);
			ln_end_x = sx16(d[47:32]);
			ln_end_y = sx16(d[63:48]);
			ln_adx   = (ln_end_x > ln_x) ? ln_end_x - ln_x : ln_x - ln_end_x;
			ln_nady  = (ln_end_y > ln_y) ? ln_y - ln_end_y : ln_end_y - ln_y;
			ln_xneg  = !(ln_x < ln_end_x);
			ln_yneg  = !(ln_y < ln_end_y);
			ln_err   = ln_adx + ln_nady;
			ln_color = d[95:64];
			ln_active = 1;
		end else if (ln_active) begin
			p.x     = ln_x[15:0];
			p.y     = ln_y[15:0];
			p.vis   = ln_x >= clp_left && ln_x < clp_left + clp_w &&
			          ln_y >= clp_top && ln_y < clp_top + clp_h;
			p.color = ln_color;
			p.last  = (ln_x == ln_end_x) && (ln_y == ln_end_y);
			pixel_q = {pixel_q, p};
			if (p.last) begin
				ln_active = 0;
			end else begin
				e2 = 2 * ln_err;
				if (e2 >= ln_nady) begin
					ln_err += ln_nady;
					ln_x   += ln_xneg ? -1 : 1;
				end
				if (e2 <= ln_adx) begin
					ln_err += ln_adx;
					ln_y   += ln_yneg ? -1 : 1;
				end
			end
		end
	endfunction

	// receiver: random stalls, one long hold on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= 300;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				if (err_count < 10)
					$display("unexpected pixel: x=%0d y=%0d vis=%0b color=%h last=%0b",
						$signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser,
						m_tdata[63:32], m_tlast);
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata[15:0] !== want.x || m_tdata[31:16] !== want.y ||
						m_tuser !== want.vis || m_tdata[63:32] !== want.color ||
						m_tlast !== want.last) begin
					if (err_count < 10) begin
						$write("pixel mismatch: exp x=%0d y=%0d vis=%0b color=%h last=%0b, ",
							want.x, want.y, want.vis, want.color, want.last);
						$display("got x=%0d y=%0d vis=%0b color=%h last=%0b",
							$signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser,
							m_tdata[63:32], m_tlast);
					end
					err_count++;
				end
			end
		end
	end

	task automatic send_item(logic cmd, logic [IN_W-1:0] d);
		while (!calm && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		predict_raster(cmd, d);
		items_sent++;
	endtask

	task automatic step_n(int n);
		repeat (n) send_item(clr_pkg::CMD_STEP, {$urandom, $urandom, $urandom});
	endtask

	// drain all pixels, then give the block time to go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [clr_pkg::IDX_W-1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			clr_pkg::REG_CLIP_LEFT:   clp_left = sx16(val);
			clr_pkg::REG_CLIP_TOP:    clp_top  = sx16(val);
			clr_pkg::REG_CLIP_WIDTH:  clp_w    = longint'(val);
			clr_pkg::REG_CLIP_HEIGHT: clp_h    = longint'(val);
			default: ;
		endcase
	endtask

	task automatic set_clip(logic [15:0] left, logic [15:0] top, logic [15:0] w, logic [15:0] h);
		settle();
		write_reg(clr_pkg::REG_CLIP_LEFT, left);
		write_reg(clr_pkg::REG_CLIP_TOP, top);
		write_reg(clr_pkg::REG_CLIP_WIDTH, w);
		write_reg(clr_pkg::REG_CLIP_HEIGHT, h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] near_coord(longint org, longint span);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return 16'(org + $urandom_range(0, 16 + (span < 40 ? span : 40)) - 8);
		else if (pick < 7)
			return 16'(org + span + $urandom_range(0, 8) - 4);
		return 16'($urandom);
	endfunction

	// start a line around the clip window, then step it to its end, past it, or abandon it
	task automatic random_line(int max_steps);
		logic [15:0] x0, y0, x1, y1;
		longint adx, ady, len, n;
		int r;
		x0 = near_coord(clp_left, clp_w);
		y0 = near_coord(clp_top, clp_h);
		r  = $urandom_range(0, 99);
		if (r < 6) begin
			x1 = x0;
			y1 = y0;
		end else if (r < 10) begin
			x1 = 16'($urandom);
			y1 = 16'($urandom);
		end else begin
			x1 = x0 + 16'($urandom_range(0, 24)) - 16'd12;
			y1 = y0 + 16'($urandom_range(0, 24)) - 16'd12;
		end
		adx = sx16(x1) - sx16(x0);
		ady = sx16(y1) - sx16(y0);
		if (adx < 0) adx = -adx;
		if (ady < 0) ady = -ady;
		len = (adx > ady ? adx : ady) + 1;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = len;
		else if (r < 85)
			n = len + $urandom_range(1, 2);
		else
			n = $urandom_range(0, int'(len > 1000 ? 1000 : len - 1));
		if (n > max_steps) n = max_steps;
		send_item(clr_pkg::CMD_START, line_word(x0, y0, x1, y1, $urandom));
		step_n(int'(n));
	endtask

	task automatic test_directed_cases();
		step_n(1);
		send_item(clr_pkg::CMD_START, line_word(16'sd5, 16'sd5, 16'sd5, 16'sd5, 32'hFFFF_FFFF));
		step_n(2);
		send_item(clr_pkg::CMD_START,
			line_word(16'h8000, 16'h8000, 16'h8002, 16'h8001, 32'h0000_0000));
		step_n(3);
		send_item(clr_pkg::CMD_START,
			line_word(16'h7FFF, 16'h7FFF, 16'h7FFD, 16'h7FFF, 32'hA5C3_3C5A));
		step_n(3);
		// widest deltas, replaced by a new line mid-way
		send_item(clr_pkg::CMD_START,
			line_word(16'h8000, -16'sd5, 16'h7FFF, 16'sd3, 32'h5A3C_C3A5));
		step_n(2);
		send_item(clr_pkg::CMD_START, line_word(16'd1023, 16'd767, 16'd1024, 16'd768, 32'h1234_5678));
		step_n(2);
		send_item(clr_pkg::CMD_START, line_word(16'd0, 16'd0, -16'sd1, -16'sd1, 32'h8765_4321));
		step_n(2);
	endtask

	task automatic test_clip_extremes();
		set_clip(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		repeat (5) random_line(30);
		set_clip(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
		repeat (4) random_line(30);
		set_clip(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
		repeat (5) random_line(30);
		set_clip(16'h0000, 16'h0000, 16'h0000, 16'd768);
		repeat (4) random_line(30);
		set_clip(16'h0000, 16'h0000, 16'd1024, 16'h0000);
		repeat (4) random_line(30);
	endtask

	task automatic test_random_clips();
		int target;
		repeat (5) begin
			set_clip($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32),
				$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32),
				$urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64)),
				$urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64)));
			target = items_sent + 70;
			while (items_sent < target) random_line(40);
		end
	endtask

	task automatic test_output_hold();
		set_clip(-16'sd50, -16'sd2, 16'd100, 16'd4);
		hold_req <= 1'b1;
		send_item(clr_pkg::CMD_START, line_word(-16'sd100, 16'sd0, 16'sd100, 16'sd5, $urandom));
		step_n(60);
		settle();
	endtask

	task automatic test_no_gaps();
		int target;
		calm <= 1'b1;
		target = items_sent + 120;
		while (items_sent < target) random_line(40);
		settle();
		calm <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_clip_extremes();
		test_random_clips();
		test_output_hold();
		test_no_gaps();
		settle();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
rtl/clr_pkg.sv
rtl/clr_cfg.sv
rtl/clr_engine.sv
rtl/clr_out_reg.sv
rtl/clipped_line_rasterizer_top.sv
verif/clipped_line_rasterizer_top_tb.sv
